/* src/sik_pkg.sv */
// shared constants, types and helper functions for the swerve kinematics block
package sik_pkg;

  // angle and cordic sizing
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_W      = 51;
  localparam int ATAN_ENTRIES  = 24;

  // datapath widths
  localparam int VEC_W      = 29;
  localparam int MAG_W      = 28;
  localparam int RAD_W      = 2 * MAG_W;
  localparam int REM_W      = MAG_W + 2;
  localparam int PERIM_W    = 13;
  localparam int SPEED_FRAC = 6;
  localparam int TWO_PI_SH  = 28;
  localparam int Q_SHIFT    = TWO_PI_SH - SPEED_FRAC;
  localparam int PROD_W     = 59;
  localparam int RAW_W      = PROD_W - Q_SHIFT;
  localparam int DIV_W      = RAW_W;
  localparam int LIM_W      = 16 + SPEED_FRAC;
  localparam int SPLIT      = 18;

  // 2*pi in q28, split into two partial products
  localparam logic [14:0] K_HI = 15'h6487;
  localparam logic [15:0] K_LO = 16'hED51;

  // cell counts and latencies
  localparam int SQRT_STEPS  = MAG_W;
  localparam int SPEED_STEPS = RAW_W;
  localparam int SCALE_STEPS = LIM_W;
  localparam int SPEED_LAT   = 2 + SQRT_STEPS + 2 + SPEED_STEPS;
  localparam int GOAL_PAD    = SPEED_LAT - CORDIC_STAGES - 2;
  localparam int POST_LAT    = 4 + SCALE_STEPS;
  localparam int TOTAL_LAT   = 2 + SPEED_LAT + POST_LAT + 1;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN32 [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef logic [ANGLE_BITS-1:0] angle_t;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_TRACK    = 3'd0,
    REG_BASE     = 3'd1,
    REG_PERIM_LF = 3'd2,
    REG_PERIM_RF = 3'd3,
    REG_PERIM_LB = 3'd4,
    REG_PERIM_RB = 3'd5,
    REG_MAX      = 3'd6
  } reg_idx_t;

  // what one wheel hands back to the top level
  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic [15:0]      goal;
  } wheel_out_t;

  // one result beat, index 0..3 = lf, rf, lb, rb
  typedef struct packed {
    logic [3:0][15:0] speed;
    logic [3:0][15:0] goal;
  } res_t;

  // rounded atan step for stage i
  function automatic angle_t atan_step(input int i);
    logic [32:0] t;
    t = {1'b0, ATAN32[i]} + (33'd1 << (31 - ANGLE_BITS));
    return ANGLE_BITS'(t >> (32 - ANGLE_BITS));
  endfunction

  // turn accumulator to 16-bit binary angle
  function automatic logic [15:0] ang16(input angle_t a);
    logic [ANGLE_BITS:0] t;
    if (ANGLE_BITS > 16) begin
      t = {1'b0, a} + ((ANGLE_BITS + 1)'(1) << (ANGLE_BITS > 16 ? ANGLE_BITS - 17 : 0));
      return 16'(t >> (ANGLE_BITS - 16));
    end
    t = '0;
    return 16'({a, 16'b0} >> ANGLE_BITS) | 16'(t);
  endfunction

  // wrapped angular distance, half a turn counts as 32768
  function automatic logic [16:0] dist16(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] e;
    e = a - b;
    return e[15] ? (17'h10000 - {1'b0, e}) : {1'b0, e};
  endfunction

endpackage

/* src/sik_sqrt_cell.sv */
// one bit of a pipelined integer square root
module sik_sqrt_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [sik_pkg::REM_W-1:0]    rem_in,
  input  logic [sik_pkg::MAG_W-1:0]    root_in,
  input  logic [sik_pkg::RAD_W-1:0]    rad_in,
  output logic [sik_pkg::REM_W-1:0]    rem_r,
  output logic [sik_pkg::MAG_W-1:0]    root_r,
  output logic [sik_pkg::RAD_W-1:0]    rad_r
);

  logic [sik_pkg::REM_W+1:0] rem_sh;
  logic [sik_pkg::REM_W+1:0] trial;
  logic                      ge;

  // bring in two radicand bits and try root*4+1
  always_comb begin
    rem_sh = {rem_in, rad_in[sik_pkg::RAD_W-1 -: 2]};
    trial  = (sik_pkg::REM_W + 2)'({root_in, 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? sik_pkg::REM_W'(rem_sh - trial) : sik_pkg::REM_W'(rem_sh);
      root_r <= {root_in[sik_pkg::MAG_W-2:0], ge};
      rad_r  <= rad_in << 2;
    end
  end

endmodule

/* src/sik_div_cell.sv */
// one quotient bit of a pipelined restoring divider
module sik_div_cell (
  input  logic                       clk,
  input  logic                       en,
  input  logic [sik_pkg::DIV_W-1:0]  rem_in,
  input  logic [sik_pkg::DIV_W-1:0]  nq_in,
  input  logic [sik_pkg::DIV_W-1:0]  dvs_in,
  output logic [sik_pkg::DIV_W-1:0]  rem_r,
  output logic [sik_pkg::DIV_W-1:0]  nq_r,
  output logic [sik_pkg::DIV_W-1:0]  dvs_r
);

  logic [sik_pkg::DIV_W:0] rem_sh;
  logic                    ge;

  // shift in the next dividend bit and compare against the divisor
  always_comb begin
    rem_sh = {rem_in, nq_in[sik_pkg::DIV_W-1]};
    ge     = rem_sh >= {1'b0, dvs_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? sik_pkg::DIV_W'(rem_sh - {1'b0, dvs_in}) : sik_pkg::DIV_W'(rem_sh);
      nq_r  <= {nq_in[sik_pkg::DIV_W-2:0], ge};
      dvs_r <= dvs_in;
    end
  end

endmodule

/* src/sik_cordic_cell.sv */
// one micro-rotation of a vectoring cordic
module sik_cordic_cell (
  input  logic                                clk,
  input  logic                                en,
  input  logic [4:0]                          sh,
  input  sik_pkg::angle_t                     step,
  input  logic signed [sik_pkg::CORDIC_W-1:0] x_in,
  input  logic signed [sik_pkg::CORDIC_W-1:0] y_in,
  input  sik_pkg::angle_t                     acc_in,
  output logic signed [sik_pkg::CORDIC_W-1:0] x_r,
  output logic signed [sik_pkg::CORDIC_W-1:0] y_r,
  output sik_pkg::angle_t                     acc_r
);

  logic signed [sik_pkg::CORDIC_W-1:0] dx;
  logic signed [sik_pkg::CORDIC_W-1:0] dy;

  // arithmetic shifts round toward minus infinity
  always_comb begin
    dx = y_in >>> sh;
    dy = x_in >>> sh;
  end

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[sik_pkg::CORDIC_W-1]) begin
        x_r   <= x_in + dx;
        y_r   <= y_in - dy;
        acc_r <= acc_in + step;
      end else begin
        x_r   <= x_in - dx;
        y_r   <= y_in + dy;
        acc_r <= acc_in - step;
      end
    end
  end

endmodule

/* src/sik_wheel.sv */
// one wheel: vector length, raw speed and steering goal
module sik_wheel (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [sik_pkg::VEC_W-1:0]   vec_x,
  input  logic signed [sik_pkg::VEC_W-1:0]   vec_y,
  input  logic [15:0]                        steer_now,
  input  logic [sik_pkg::PERIM_W-1:0]        perim,
  output sik_pkg::wheel_out_t                res
);

  localparam int CS = sik_pkg::CORDIC_STAGES;

  // magnitudes and squares
  logic [sik_pkg::MAG_W-1:0] ax, ay;
  logic [sik_pkg::RAD_W-1:0] sqx_r, sqy_r, rad_r;

  always_comb begin
    ax = vec_x[sik_pkg::VEC_W-1] ? sik_pkg::MAG_W'(-vec_x) : sik_pkg::MAG_W'(vec_x);
    ay = vec_y[sik_pkg::VEC_W-1] ? sik_pkg::MAG_W'(-vec_y) : sik_pkg::MAG_W'(vec_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= ax * ax;
      sqy_r <= ay * ay;
      rad_r <= sqx_r + sqy_r;
    end
  end

  // square root chain
  logic [sik_pkg::REM_W-1:0] rem_c  [sik_pkg::SQRT_STEPS+1];
  logic [sik_pkg::MAG_W-1:0] root_c [sik_pkg::SQRT_STEPS+1];
  logic [sik_pkg::RAD_W-1:0] rad_c  [sik_pkg::SQRT_STEPS+1];

  assign rem_c[0]  = '0;
  assign root_c[0] = '0;
  assign rad_c[0]  = rad_r;

  for (genvar k = 0; k < sik_pkg::SQRT_STEPS; k++) begin : g_sqrt
    sik_sqrt_cell u_cell (
      .clk     (clk),
      .en      (en),
      .rem_in  (rem_c[k]),
      .root_in (root_c[k]),
      .rad_in  (rad_c[k]),
      .rem_r   (rem_c[k+1]),
      .root_r  (root_c[k+1]),
      .rad_r   (rad_c[k+1])
    );
  end

  // length times 2*pi, two partial products then the sum
  logic [sik_pkg::MAG_W+14:0]  ph_r;
  logic [sik_pkg::MAG_W+15:0]  pl_r;
  logic [sik_pkg::PROD_W-1:0]  prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r   <= root_c[sik_pkg::SQRT_STEPS] * sik_pkg::K_HI;
      pl_r   <= root_c[sik_pkg::SQRT_STEPS] * sik_pkg::K_LO;
      prod_r <= (sik_pkg::PROD_W'(ph_r) << 16) + sik_pkg::PROD_W'(pl_r);
    end
  end

  // divide by perimeter scaled to drop the extra fraction bits
  logic [sik_pkg::DIV_W-1:0] drem_c [sik_pkg::SPEED_STEPS+1];
  logic [sik_pkg::DIV_W-1:0] dnq_c  [sik_pkg::SPEED_STEPS+1];
  logic [sik_pkg::DIV_W-1:0] ddv_c  [sik_pkg::SPEED_STEPS+1];

  assign drem_c[0] = sik_pkg::DIV_W'(prod_r[sik_pkg::PROD_W-1:sik_pkg::SPEED_STEPS]);
  assign dnq_c[0]  = prod_r[sik_pkg::SPEED_STEPS-1:0];
  assign ddv_c[0]  = sik_pkg::DIV_W'({perim, {sik_pkg::Q_SHIFT{1'b0}}});

  for (genvar k = 0; k < sik_pkg::SPEED_STEPS; k++) begin : g_div
    sik_div_cell u_cell (
      .clk    (clk),
      .en     (en),
      .rem_in (drem_c[k]),
      .nq_in  (dnq_c[k]),
      .dvs_in (ddv_c[k]),
      .rem_r  (drem_c[k+1]),
      .nq_r   (dnq_c[k+1]),
      .dvs_r  (ddv_c[k+1])
    );
  end

  // cordic prep: fold left half plane, scale up
  logic signed [sik_pkg::CORDIC_W-1:0] xs, ys;
  logic signed [sik_pkg::CORDIC_W-1:0] x_c   [CS+1];
  logic signed [sik_pkg::CORDIC_W-1:0] y_c   [CS+1];
  sik_pkg::angle_t                     acc_c [CS+1];
  logic signed [sik_pkg::CORDIC_W-1:0] cx_r, cy_r;
  sik_pkg::angle_t                     cacc_r;
  logic [CS:0]                         zd_r;
  logic [15:0]                         cd_r [CS+1];

  always_comb begin
    xs = sik_pkg::CORDIC_W'(vec_x) <<< 20;
    ys = sik_pkg::CORDIC_W'(vec_y) <<< 20;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r   <= vec_x[sik_pkg::VEC_W-1] ? -xs : xs;
      cy_r   <= vec_x[sik_pkg::VEC_W-1] ? -ys : ys;
      cacc_r <= vec_x[sik_pkg::VEC_W-1] ? {1'b1, {(sik_pkg::ANGLE_BITS-1){1'b0}}} : '0;
      zd_r   <= {zd_r[CS-1:0], (vec_x == '0) && (vec_y == '0)};
      cd_r[0] <= steer_now;
      for (int k = 1; k <= CS; k++) begin
        cd_r[k] <= cd_r[k-1];
      end
    end
  end

  assign x_c[0]   = cx_r;
  assign y_c[0]   = cy_r;
  assign acc_c[0] = cacc_r;

  for (genvar k = 0; k < CS; k++) begin : g_cordic
    sik_cordic_cell u_cell (
      .clk    (clk),
      .en     (en),
      .sh     (5'(k)),
      .step   (sik_pkg::atan_step(k)),
      .x_in   (x_c[k]),
      .y_in   (y_c[k]),
      .acc_in (acc_c[k]),
      .x_r    (x_c[k+1]),
      .y_r    (y_c[k+1]),
      .acc_r  (acc_c[k+1])
    );
  end

  // pick the direct or flipped angle, whichever is closer
  logic [15:0] t, tf;
  logic [15:0] goal_r;
  logic [15:0] gd_r [sik_pkg::GOAL_PAD];

  always_comb begin
    t  = zd_r[CS] ? 16'h0000 : sik_pkg::ang16(acc_c[CS]);
    tf = t + 16'h8000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      goal_r <= (sik_pkg::dist16(t, cd_r[CS]) < sik_pkg::dist16(tf, cd_r[CS])) ? t : tf;
      gd_r[0] <= goal_r;
      for (int k = 1; k < sik_pkg::GOAL_PAD; k++) begin
        gd_r[k] <= gd_r[k-1];
      end
    end
  end

  assign res.raw  = dnq_c[sik_pkg::SPEED_STEPS];
  assign res.goal = gd_r[sik_pkg::GOAL_PAD-1];

endmodule

/* src/swerve_inverse_kinematics.sv */
// swerve drive inverse kinematics, top level
//
//   channel | ports                           | width
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata | 3 + 16, write only
//   in      | in_valid / in_ready             | 3 x 16 signed + 4 x 16 steer
//   out     | out_valid / out_ready           | 4 x 16 speed + 4 x 16 steer goal
//
// one beat per cycle in while the output buffer is not full
// pipeline depth comes mostly from the perimeter divider (37 cells), square root (28 cells)
// and the limit-scaling divider (22 cells), all running in one pipeline
// a two-entry output buffer keeps input open while a result waits; the whole
// pipeline holds only when that buffer is full
// rst_n is synchronous; config registers return to their defaults
module swerve_inverse_kinematics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_lin_vel_x,
  input  logic signed [15:0] in_lin_vel_y,
  input  logic signed [15:0] in_yaw_rate,
  input  logic [15:0]        in_steer_now_lf,
  input  logic [15:0]        in_steer_now_rf,
  input  logic [15:0]        in_steer_now_lb,
  input  logic [15:0]        in_steer_now_rb,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_speed_lf,
  output logic [15:0]        out_speed_rf,
  output logic [15:0]        out_speed_lb,
  output logic [15:0]        out_speed_rb,
  output logic [15:0]        out_steer_goal_lf,
  output logic [15:0]        out_steer_goal_rf,
  output logic [15:0]        out_steer_goal_lb,
  output logic [15:0]        out_steer_goal_rb
);

  localparam int VW = sik_pkg::VEC_W;
  localparam int DW = sik_pkg::DIV_W;
  localparam int SS = sik_pkg::SCALE_STEPS;

  // configuration registers
  logic [11:0]                   track_r, base_r;
  logic [3:0][sik_pkg::PERIM_W-1:0] perim_r;
  logic [15:0]                   max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= 12'd500;
      base_r  <= 12'd500;
      perim_r <= {4{13'd480}};
      max_r   <= 16'd30000;
    end else if (cfg_wr_en) begin
      unique case (sik_pkg::reg_idx_t'(cfg_index))
        sik_pkg::REG_TRACK:    track_r    <= cfg_wdata[11:0];
        sik_pkg::REG_BASE:     base_r     <= cfg_wdata[11:0];
        sik_pkg::REG_PERIM_LF: perim_r[0] <= cfg_wdata[12:0];
        sik_pkg::REG_PERIM_RF: perim_r[1] <= cfg_wdata[12:0];
        sik_pkg::REG_PERIM_LB: perim_r[2] <= cfg_wdata[12:0];
        sik_pkg::REG_PERIM_RB: perim_r[3] <= cfg_wdata[12:0];
        sik_pkg::REG_MAX:      max_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance and valid chain
  logic                          en;
  logic [1:0]                    cnt_r;
  logic [sik_pkg::TOTAL_LAT-1:0] vld_r;

  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[sik_pkg::TOTAL_LAT-2:0], in_valid};
    end
  end

  // stage 1: products
  logic signed [25:0] vx_e, vy_e;
  logic signed [VW-1:0] yaw_e, trk_e, bas_e;
  logic signed [25:0] px_r, py_r;
  logic signed [VW-1:0] yt_r, yb_r;
  logic [3:0][15:0] cur1_r, cur2_r;

  always_comb begin
    vx_e  = 26'(in_lin_vel_x);
    vy_e  = 26'(in_lin_vel_y);
    yaw_e = VW'(in_yaw_rate);
    trk_e = VW'($signed({1'b0, track_r}));
    bas_e = VW'($signed({1'b0, base_r}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= vx_e * 26'sd1000;
      py_r   <= vy_e * 26'sd1000;
      yt_r   <= yaw_e * trk_e;
      yb_r   <= yaw_e * bas_e;
      cur1_r <= {in_steer_now_rb, in_steer_now_lb, in_steer_now_rf, in_steer_now_lf};
      cur2_r <= cur1_r;
    end
  end

  // stage 2: wheel vectors, track sign - + - +, base sign + + - -
  logic signed [VW-1:0] wx_r [4];
  logic signed [VW-1:0] wy_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r[0] <= VW'(px_r) - yt_r;
      wx_r[1] <= VW'(px_r) + yt_r;
      wx_r[2] <= VW'(px_r) - yt_r;
      wx_r[3] <= VW'(px_r) + yt_r;
      wy_r[0] <= VW'(py_r) + yb_r;
      wy_r[1] <= VW'(py_r) + yb_r;
      wy_r[2] <= VW'(py_r) - yb_r;
      wy_r[3] <= VW'(py_r) - yb_r;
    end
  end

  // per-wheel datapaths
  sik_pkg::wheel_out_t wo [4];

  for (genvar w = 0; w < 4; w++) begin : g_wheel
    sik_wheel u_wheel (
      .clk       (clk),
      .en        (en),
      .vec_x     (wx_r[w]),
      .vec_y     (wy_r[w]),
      .steer_now (cur2_r[w]),
      .perim     ((perim_r[w] == '0) ? sik_pkg::PERIM_W'(1) : perim_r[w]),
      .res       (wo[w])
    );
  end

  // largest raw speed over a two-level tree, then scale products
  logic [sik_pkg::LIM_W-1:0] lim;
  logic [DW-1:0] raw_a_r [4];
  logic [DW-1:0] raw_b_r [4];
  logic [DW-1:0] raw_c_r [4];
  logic [DW-1:0] raw_d_r [4];
  logic [DW-1:0] m01_r, m23_r, rmax_r, rmax_c_r, rmax_d_r;
  logic          scl_c_r, scl_d_r;
  logic [DW-sik_pkg::SPLIT+sik_pkg::LIM_W-1:0] hi_r [4];
  logic [sik_pkg::SPLIT+sik_pkg::LIM_W-1:0]    lo_r [4];
  logic [sik_pkg::PROD_W-1:0] num_r [4];

  assign lim = {max_r, {sik_pkg::SPEED_FRAC{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      m01_r    <= (wo[0].raw > wo[1].raw) ? wo[0].raw : wo[1].raw;
      m23_r    <= (wo[2].raw > wo[3].raw) ? wo[2].raw : wo[3].raw;
      rmax_r   <= (m01_r > m23_r) ? m01_r : m23_r;
      rmax_c_r <= rmax_r;
      scl_c_r  <= rmax_r > DW'(lim);
      rmax_d_r <= rmax_c_r;
      scl_d_r  <= scl_c_r;
      for (int w = 0; w < 4; w++) begin
        raw_a_r[w] <= wo[w].raw;
        raw_b_r[w] <= raw_a_r[w];
        raw_c_r[w] <= raw_b_r[w];
        hi_r[w]    <= raw_b_r[w][DW-1:sik_pkg::SPLIT] * lim;
        lo_r[w]    <= raw_b_r[w][sik_pkg::SPLIT-1:0] * lim;
        raw_d_r[w] <= raw_c_r[w];
        num_r[w]   <= (sik_pkg::PROD_W'(hi_r[w]) << sik_pkg::SPLIT)
                      + sik_pkg::PROD_W'(lo_r[w]);
      end
    end
  end

  // scaling dividers, raw*limit / largest raw
  logic [DW-1:0] sr_c [4][SS+1];
  logic [DW-1:0] sq_c [4][SS+1];
  logic [DW-1:0] sv_c [4][SS+1];

  for (genvar w = 0; w < 4; w++) begin : g_scale
    assign sr_c[w][0] = DW'(num_r[w][sik_pkg::PROD_W-1:SS]);
    assign sq_c[w][0] = {num_r[w][SS-1:0], {(DW-SS){1'b0}}};
    assign sv_c[w][0] = rmax_d_r;
    for (genvar k = 0; k < SS; k++) begin : g_cell
      sik_div_cell u_cell (
        .clk    (clk),
        .en     (en),
        .rem_in (sr_c[w][k]),
        .nq_in  (sq_c[w][k]),
        .dvs_in (sv_c[w][k]),
        .rem_r  (sr_c[w][k+1]),
        .nq_r   (sq_c[w][k+1]),
        .dvs_r  (sv_c[w][k+1])
      );
    end
  end

  // side delays for raw speeds, scale flag and goals
  logic [DW-1:0]    rd_r  [4][SS];
  logic [SS-1:0]    sd_r;
  logic [3:0][15:0] gdl_r [sik_pkg::POST_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r     <= {sd_r[SS-2:0], scl_d_r};
      gdl_r[0] <= {wo[3].goal, wo[2].goal, wo[1].goal, wo[0].goal};
      for (int k = 1; k < sik_pkg::POST_LAT; k++) begin
        gdl_r[k] <= gdl_r[k-1];
      end
      for (int w = 0; w < 4; w++) begin
        rd_r[w][0] <= raw_d_r[w];
        for (int k = 1; k < SS; k++) begin
          rd_r[w][k] <= rd_r[w][k-1];
        end
      end
    end
  end

  // final rounding and saturation
  logic [DW-1:0]    sel  [4];
  logic [DW:0]      rnd  [4];
  logic [3:0][15:0] spd;
  sik_pkg::res_t    res_r;

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      sel[w] = sd_r[SS-1] ? DW'(sq_c[w][SS][SS-1:0]) : rd_r[w][SS-1];
      rnd[w] = (DW + 1)'(sel[w]) + (DW + 1)'(1 << (sik_pkg::SPEED_FRAC - 1));
      spd[w] = (|rnd[w][DW:16+sik_pkg::SPEED_FRAC]) ? 16'hFFFF
               : rnd[w][15+sik_pkg::SPEED_FRAC:sik_pkg::SPEED_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.speed <= spd;
      res_r.goal  <= gdl_r[sik_pkg::POST_LAT-1];
    end
  end

  // two-entry output buffer
  sik_pkg::res_t mem_r [2];
  logic          wp_r, rp_r;
  logic          push, pop;

  assign push      = en && vld_r[sik_pkg::TOTAL_LAT-1];
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      priority if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end else begin
        cnt_r <= cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= res_r;
    end
  end

  assign out_speed_lf      = mem_r[rp_r].speed[0];
  assign out_speed_rf      = mem_r[rp_r].speed[1];
  assign out_speed_lb      = mem_r[rp_r].speed[2];
  assign out_speed_rb      = mem_r[rp_r].speed[3];
  assign out_steer_goal_lf = mem_r[rp_r].goal[0];
  assign out_steer_goal_rf = mem_r[rp_r].goal[1];
  assign out_steer_goal_lb = mem_r[rp_r].goal[2];
  assign out_steer_goal_rb = mem_r[rp_r].goal[3];

endmodule

/* src/sik_checker.sv */
// port-level checks for the swerve kinematics block, bound to the top level
module sik_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        out_speed_lf,
  input logic [15:0]        out_speed_rf,
  input logic [15:0]        out_speed_lb,
  input logic [15:0]        out_speed_rb,
  input logic [15:0]        out_steer_goal_lf,
  input logic [15:0]        out_steer_goal_rf,
  input logic [15:0]        out_steer_goal_lb,
  input logic [15:0]        out_steer_goal_rb
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable(out_speed_lf) && $stable(out_speed_rf)
      && $stable(out_speed_lb) && $stable(out_speed_rb)
      && $stable(out_steer_goal_lf) && $stable(out_steer_goal_rf)
      && $stable(out_steer_goal_lb) && $stable(out_steer_goal_rb))
    else $error("stalled output beat changed");

  // after reset the block is empty and open
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not empty after reset");

  // input only closes when results are waiting
  a_closed_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input closed with no result pending");

  // buffer full and nothing taken keeps input closed
  a_stay_closed: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !out_ready |=> !in_ready)
    else $error("input reopened without a result taken");

endmodule

bind swerve_inverse_kinematics sik_checker u_sik_checker (.*);

/* test/tb_top.sv */
// self-checking testbench for the swerve drive inverse kinematics block
module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = 3'd0;
  logic [15:0] cfg_wdata = 16'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_lin_vel_x = '0, in_lin_vel_y = '0, in_yaw_rate = '0;
  logic [15:0] in_steer_now_lf = '0, in_steer_now_rf = '0;
  logic [15:0] in_steer_now_lb = '0, in_steer_now_rb = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_speed_lf, out_speed_rf, out_speed_lb, out_speed_rb;
  logic [15:0] out_steer_goal_lf, out_steer_goal_rf, out_steer_goal_lb, out_steer_goal_rb;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] yaw;
    logic [3:0][15:0]   steer;
  } cmd_t;

  swerve_inverse_kinematics dut (.*);

  always #5 clk = ~clk;

  // geometry copy used by the predictor
  logic [11:0] track_mm, base_mm;
  logic [12:0] perim_mm [4];
  logic [15:0] speed_cap;

  cmd_t          cmd_q [$];
  sik_pkg::res_t wheel_q [$];
  int   errors = 0;
  int   send_idle = 11, recv_idle = 82;
  bit   hold_send = 1'b0;

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  // cordic vectoring, 16 stages, 16-bit turn accumulator
  function automatic logic [15:0] heading(input longint x, input longint y);
    logic [15:0] acc;
    logic [31:0] a;
    longint dx, dy;
    acc = 0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 16'h8000;
    end
    x = x * 1048576;
    y = y * 1048576;
    for (int i = 0; i < sik_pkg::CORDIC_STAGES; i++) begin
      a = (sik_pkg::ATAN32[i] + 32'd32768) >> 16;
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        acc = acc + a[15:0];
      end else begin
        x = x - dx;
        y = y + dy;
        acc = acc - a[15:0];
      end
    end
    return acc;
  endfunction

  function automatic int wrap_gap(input logic [15:0] a, input logic [15:0] b);
    logic signed [15:0] e;
    int v;
    e = a - b;
    v = e;
    return v < 0 ? -v : v;
  endfunction

  function automatic sik_pkg::res_t predict_wheels(input cmd_t c);
    sik_pkg::res_t r;
    longint wx, wy, st, sb;
    logic [63:0] len, p, lim, rmax, s;
    logic [127:0] prod;
    logic [63:0] raw [4];
    logic [15:0] t, tf;
    rmax = 0;
    for (int w = 0; w < 4; w++) begin
      st = (w == 0 || w == 2) ? -1 : 1;
      sb = (w < 2) ? 1 : -1;
      wx = longint'(c.vx) * 1000 + st * longint'(c.yaw) * longint'(track_mm);
      wy = longint'(c.vy) * 1000 + sb * longint'(c.yaw) * longint'(base_mm);
      len = isqrt(64'(wx * wx) + 64'(wy * wy));
      p = perim_mm[w] == 0 ? 64'd1 : 64'(perim_mm[w]);
      prod = 128'(len) * 128'd1686629713;
      raw[w] = 64'((prod / p) >> 22);
      if (raw[w] > rmax) rmax = raw[w];
      t = heading(wx, wy);
      tf = t + 16'h8000;
      r.goal[w] = (wrap_gap(t, c.steer[w]) < wrap_gap(tf, c.steer[w])) ? t : tf;
    end
    lim = 64'(speed_cap) << 6;
    for (int w = 0; w < 4; w++) begin
      s = raw[w];
      if (rmax > lim) s = 64'((128'(s) * lim) / rmax);
      s = (s + 32) >> 6;
      r.speed[w] = s > 64'hFFFF ? 16'hFFFF : s[15:0];
    end
    return r;
  endfunction

  // driver: present queued commands
  always @(posedge clk) begin
    if (in_valid && in_ready) wheel_q.push_back(predict_wheels(cmd_q.pop_front()));
    if (!(in_valid && !in_ready)) begin
      if (rst_n && cmd_q.size() > 0 && !hold_send &&
          $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_lin_vel_x <= cmd_q[0].vx;
        in_lin_vel_y <= cmd_q[0].vy;
        in_yaw_rate <= cmd_q[0].yaw;
        in_steer_now_lf <= cmd_q[0].steer[0];
        in_steer_now_rf <= cmd_q[0].steer[1];
        in_steer_now_lb <= cmd_q[0].steer[2];
        in_steer_now_rb <= cmd_q[0].steer[3];
      end else in_valid <= 1'b0;
    end
  end

  // monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin
    sik_pkg::res_t got, want;
    if (out_valid && out_ready) begin
      got.speed = {out_speed_rb, out_speed_lb, out_speed_rf, out_speed_lf};
      got.goal = {out_steer_goal_rb, out_steer_goal_lb, out_steer_goal_rf, out_steer_goal_lf};
      if (wheel_q.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = wheel_q.pop_front();
        for (int w = 0; w < 4; w++) begin
          if (got.speed[w] !== want.speed[w]) begin
            $display("%0t speed[%0d]: expected %0d, actual %0d", $time, w,
                     want.speed[w], got.speed[w]);
            errors++;
          end
          if (got.goal[w] !== want.goal[w]) begin
            $display("%0t goal[%0d]: expected %h, actual %h", $time, w,
                     want.goal[w], got.goal[w]);
            errors++;
          end
        end
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  task automatic add_cmd(input int vx, input int vy, input int yaw, input bit rand_steer);
    cmd_t c;
    c.vx = 16'(vx);
    c.vy = 16'(vy);
    c.yaw = 16'(yaw);
    for (int w = 0; w < 4; w++) c.steer[w] = rand_steer ? 16'($urandom) : 16'(w * 'h4000);
    cmd_q.push_back(c);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: add_cmd($urandom, $urandom, $urandom, 1);
        1: add_cmd($signed($urandom_range(4000)) - 2000, $signed($urandom_range(4000)) - 2000,
                   $signed($urandom_range(4000)) - 2000, 1);
        2: add_cmd(0, $urandom, 0, 1);
        default: add_cmd($urandom, 0, $urandom_range(1) ? 16'sh7FFF : 16'sh8000, 1);
      endcase
    end
  endtask

  task automatic drain();
    wait (cmd_q.size() == 0 && !in_valid && wheel_q.size() == 0);
    repeat (sik_pkg::TOTAL_LAT + 10) @(posedge clk);
  endtask

  task automatic write_reg(input sik_pkg::reg_idx_t idx, input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      sik_pkg::REG_TRACK: track_mm = v[11:0];
      sik_pkg::REG_BASE:  base_mm = v[11:0];
      sik_pkg::REG_MAX:   speed_cap = v;
      default:            perim_mm[idx - sik_pkg::REG_PERIM_LF] = v[12:0];
    endcase
  endtask

  task automatic set_geometry(input int t, input int b, input int p0, input int p1,
                              input int p2, input int p3, input int m);
    write_reg(sik_pkg::REG_TRACK, 16'(t));
    write_reg(sik_pkg::REG_BASE, 16'(b));
    write_reg(sik_pkg::REG_PERIM_LF, 16'(p0));
    write_reg(sik_pkg::REG_PERIM_RF, 16'(p1));
    write_reg(sik_pkg::REG_PERIM_LB, 16'(p2));
    write_reg(sik_pkg::REG_PERIM_RB, 16'(p3));
    write_reg(sik_pkg::REG_MAX, 16'(m));
  endtask

  // stimulus
  initial begin
    track_mm = 500;
    base_mm = 500;
    for (int w = 0; w < 4; w++) perim_mm[w] = 480;
    speed_cap = 30000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero vector, extremes, ties and half-turn flips
    add_cmd(0, 0, 0, 0);
    add_cmd(0, 0, 0, 1);
    add_cmd(32767, 32767, 32767, 0);
    add_cmd(-32768, -32768, -32768, 0);
    add_cmd(-32768, 0, 0, 0);
    add_cmd(0, -32768, 0, 0);
    add_cmd(0, 0, 32767, 0);
    add_cmd(0, 0, -32768, 1);
    add_cmd(1000, 0, 0, 0);
    add_cmd(0, 1000, 0, 0);
    add_cmd(-1, -1, 1, 0);
    add_cmd(1000, 1000, 0, 0);
    begin
      cmd_t c;
      c = '{vx: 100, vy: 0, yaw: 0, steer: {16'hC000, 16'h4000, 16'h8000, 16'hFFFF}};
      cmd_q.push_back(c);
      c = '{vx: 0, vy: 100, yaw: 0, steer: {16'h0000, 16'hC000, 16'h4000, 16'h8000}};
      cmd_q.push_back(c);
    end
    drain();

    set_geometry(4095, 4095, 1, 8191, 0, 1, 65535);
    add_cmd(32767, -32768, 32767, 1);
    add_cmd(1, 1, 1, 1);
    add_random(60);
    drain();

    set_geometry(1, 1, 8191, 8191, 8191, 8191, 0);
    add_cmd(0, 0, 0, 1);
    add_cmd(5, 0, 0, 1);
    add_random(40);
    drain();

    set_geometry(1234, 777, 480, 600, 300, 1000, 1);
    add_random(150);
    drain();

    // pause sending while results are outstanding until every one is back
    add_random(50);
    repeat (30) @(posedge clk);
    hold_send = 1'b1;
    wait (wheel_q.size() == 0);
    hold_send = 1'b0;
    drain();

    send_idle = 82;
    recv_idle = 11;
    set_geometry(500, 500, 480, 480, 480, 480, 30000);
    add_random(150);
    drain();

    send_idle = 0;
    recv_idle = 0;
    set_geometry(3000, 200, 2000, 100, 4000, 50, 20000);
    add_random(200);
    drain();

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

/* files.f */
src/sik_pkg.sv
src/sik_sqrt_cell.sv
src/sik_div_cell.sv
src/sik_cordic_cell.sv
src/sik_wheel.sv
src/swerve_inverse_kinematics.sv
src/sik_checker.sv
test/tb_top.sv
